### hdl/bmpb_pkg.sv
package bmpb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 800;
    localparam int SCREEN_HEIGHT_DEF = 480;
    localparam int MAX_IMAGE_DIM_DEF = 2048;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 13;
    localparam int OCOL_W     = 10;
    localparam int OROW_W     = 9;
    localparam int FB_W       = 19;
    localparam int COLOR_W    = 32;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_FOUR_BYTE    = 3'd2,
        REG_ORIGIN_COL   = 3'd3,
        REG_ORIGIN_ROW   = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_BLUE  = 2'd0,
        PH_GREEN = 2'd1,
        PH_RED   = 2'd2,
        PH_ALPHA = 2'd3
    } t_phase;

    typedef struct packed {
        logic [WIDTH_W-1:0]         image_width;
        logic signed [HEIGHT_W-1:0] image_height;
        logic                       four_byte_pixels;
        logic [OCOL_W-1:0]          origin_col;
        logic [OROW_W-1:0]          origin_row;
    } t_cfg;

    typedef struct packed {
        logic               on_screen;
        logic [FB_W-1:0]    fb_address;
        logic [COLOR_W-1:0] pixel_color;
        logic               image_done;
    } t_result;

endpackage

### hdl/bmpb_regs.sv
module bmpb_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bmpb_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [bmpb_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [bmpb_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    output bmpb_pkg::t_cfg                     o_cfg
);

    bmpb_pkg::t_cfg       r_cfg;
    bmpb_pkg::t_reg_idx   idx;
    logic                 wr;

    assign pready = 1'b1;
    assign idx    = bmpb_pkg::t_reg_idx'(paddr[4:2]);
    assign wr     = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width      <= bmpb_pkg::WIDTH_W'(1);
            r_cfg.image_height     <= bmpb_pkg::HEIGHT_W'(1);
            r_cfg.four_byte_pixels <= 1'b0;
            r_cfg.origin_col       <= '0;
            r_cfg.origin_row       <= '0;
        end else if (wr) begin
            case (idx)
                bmpb_pkg::REG_IMAGE_WIDTH: begin
                    r_cfg.image_width <= pwdata[bmpb_pkg::WIDTH_W-1:0];
                end
                bmpb_pkg::REG_IMAGE_HEIGHT: begin
                    r_cfg.image_height <= pwdata[bmpb_pkg::HEIGHT_W-1:0];
                end
                bmpb_pkg::REG_FOUR_BYTE: begin
                    r_cfg.four_byte_pixels <= pwdata[0];
                end
                bmpb_pkg::REG_ORIGIN_COL: begin
                    r_cfg.origin_col <= pwdata[bmpb_pkg::OCOL_W-1:0];
                end
                bmpb_pkg::REG_ORIGIN_ROW: begin
                    r_cfg.origin_row <= pwdata[bmpb_pkg::OROW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            bmpb_pkg::REG_IMAGE_WIDTH:  prdata = bmpb_pkg::CFG_DATA_W'(r_cfg.image_width);
            bmpb_pkg::REG_IMAGE_HEIGHT: prdata = bmpb_pkg::CFG_DATA_W'(
                                            unsigned'(r_cfg.image_height));
            bmpb_pkg::REG_FOUR_BYTE:    prdata = bmpb_pkg::CFG_DATA_W'(r_cfg.four_byte_pixels);
            bmpb_pkg::REG_ORIGIN_COL:   prdata = bmpb_pkg::CFG_DATA_W'(r_cfg.origin_col);
            bmpb_pkg::REG_ORIGIN_ROW:   prdata = bmpb_pkg::CFG_DATA_W'(r_cfg.origin_row);
            default:                    prdata = '0;
        endcase
    end

endmodule

### hdl/bmpb_core.sv
module bmpb_core #(
    parameter int SCREEN_WIDTH  = bmpb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = bmpb_pkg::SCREEN_HEIGHT_DEF,
    parameter int MAX_IMAGE_DIM = bmpb_pkg::MAX_IMAGE_DIM_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bmpb_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_pixel_byte,
    input  logic              i_can_take,
    output logic              o_res_vld,
    output bmpb_pkg::t_result o_res
);

    localparam int DIM_W = $clog2(MAX_IMAGE_DIM + 1);
    localparam int CNT_W = (MAX_IMAGE_DIM > 1) ? $clog2(MAX_IMAGE_DIM) : 1;
    localparam int SR_W  = $clog2(MAX_IMAGE_DIM + 512) + 2;
    localparam int SC_W  = ((CNT_W > bmpb_pkg::OCOL_W) ? CNT_W : bmpb_pkg::OCOL_W) + 1;
    localparam int HW    = bmpb_pkg::HEIGHT_W;
    localparam int FB_W  = bmpb_pkg::FB_W;
    localparam logic [HW-1:0] MAX_DIM_H = HW'(MAX_IMAGE_DIM);

    logic             r_in_vld, n_in_vld;
    logic [7:0]       r_in_byte, n_in_byte;
    bmpb_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_blue, n_blue, r_green, n_green, r_red, n_red;
    logic [CNT_W-1:0] r_col, n_col, r_row, n_row;
    logic [1:0]       r_pad, n_pad;
    logic             r_finished, n_finished;

    logic                   accept, step, ignore, emit;
    logic [HW-1:0]          w_full, h_abs;
    logic [DIM_W-1:0]       w, hmag;
    logic                   last_col, last_row, on;
    logic signed [SR_W-1:0] img_row, scr_row;
    logic [SC_W-1:0]        scr_col;
    logic [FB_W-1:0]        fb;
    logic [7:0]             alpha, red;

    assign o_ready = !r_in_vld || i_can_take;
    assign accept  = i_valid && o_ready;
    assign step    = r_in_vld && i_can_take;

    // clamped dimensions
    assign w_full = HW'(i_cfg.image_width);
    assign h_abs  = i_cfg.image_height[HW-1] ? (~i_cfg.image_height + HW'(1))
                                             : i_cfg.image_height;
    assign w      = (w_full > MAX_DIM_H) ? DIM_W'(MAX_DIM_H) : DIM_W'(w_full);
    assign hmag   = (h_abs > MAX_DIM_H) ? DIM_W'(MAX_DIM_H) : DIM_W'(h_abs);
    assign ignore = r_finished || (w == '0) || (hmag == '0);

    assign last_col = ((DIM_W+1)'(r_col) + (DIM_W+1)'(1)) >= (DIM_W+1)'(w);
    assign last_row = ((DIM_W+1)'(r_row) + (DIM_W+1)'(1)) >= (DIM_W+1)'(hmag);

    // screen placement, bottom-up rows flipped
    assign img_row = !i_cfg.image_height[HW-1]
                   ? SR_W'(hmag) - SR_W'(1) - SR_W'(r_row)
                   : SR_W'(r_row);
    assign scr_row = img_row + SR_W'(i_cfg.origin_row);
    assign scr_col = SC_W'(r_col) + SC_W'(i_cfg.origin_col);
    assign on      = !scr_row[SR_W-1] && (int'(scr_row) < SCREEN_HEIGHT)
                     && (int'(scr_col) < SCREEN_WIDTH);
    assign fb      = FB_W'(scr_row) * FB_W'(SCREEN_WIDTH) + FB_W'(scr_col);

    assign red   = (r_phase == bmpb_pkg::PH_RED) ? r_in_byte : r_red;
    assign alpha = (r_phase == bmpb_pkg::PH_ALPHA) ? r_in_byte : 8'd0;

    assign o_res_vld         = emit;
    assign o_res.on_screen   = on;
    assign o_res.fb_address  = on ? fb : '0;
    assign o_res.pixel_color = {alpha, red, r_green, r_blue};
    assign o_res.image_done  = last_col && last_row;

    always_comb begin
        n_in_vld   = accept ? 1'b1 : (step ? 1'b0 : r_in_vld);
        n_in_byte  = accept ? i_pixel_byte : r_in_byte;
        n_phase    = r_phase;
        n_blue     = r_blue;
        n_green    = r_green;
        n_red      = r_red;
        n_col      = r_col;
        n_row      = r_row;
        n_pad      = r_pad;
        n_finished = r_finished;
        emit       = 1'b0;
        if (step && !ignore) begin
            if (r_pad != 2'd0) begin
                n_pad = r_pad - 2'd1;
            end else begin
                case (r_phase)
                    bmpb_pkg::PH_BLUE: begin
                        n_blue  = r_in_byte;
                        n_phase = bmpb_pkg::PH_GREEN;
                    end
                    bmpb_pkg::PH_GREEN: begin
                        n_green = r_in_byte;
                        n_phase = bmpb_pkg::PH_RED;
                    end
                    bmpb_pkg::PH_RED: begin
                        n_red = r_in_byte;
                        if (i_cfg.four_byte_pixels) begin
                            n_phase = bmpb_pkg::PH_ALPHA;
                        end else begin
                            n_phase = bmpb_pkg::PH_BLUE;
                            emit    = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = bmpb_pkg::PH_BLUE;
                        emit    = 1'b1;
                    end
                endcase
                if (emit) begin
                    if (last_col) begin
                        n_col = '0;
                        if (last_row) begin
                            n_finished = 1'b1;
                        end else begin
                            n_row = r_row + CNT_W'(1);
                            // padding to 4 bytes equals width mod 4 for BGR rows
                            n_pad = i_cfg.four_byte_pixels ? 2'd0 : 2'(w);
                        end
                    end else begin
                        n_col = r_col + CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_phase    <= bmpb_pkg::PH_BLUE;
            r_blue     <= '0;
            r_green    <= '0;
            r_red      <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_pad      <= '0;
            r_finished <= 1'b0;
        end else begin
            r_in_vld   <= n_in_vld;
            r_phase    <= n_phase;
            r_blue     <= n_blue;
            r_green    <= n_green;
            r_red      <= n_red;
            r_col      <= n_col;
            r_row      <= n_row;
            r_pad      <= n_pad;
            r_finished <= n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_byte <= n_in_byte;
    end

endmodule

### hdl/bmpb_out.sv
module bmpb_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  bmpb_pkg::t_result i_res,
    output logic              o_can_take,
    output logic              o_valid,
    input  logic              i_ready,
    output bmpb_pkg::t_result o_res
);

    logic              r_vld, n_vld;
    bmpb_pkg::t_result r_res, n_res;

    assign o_can_take = !r_vld || i_ready;
    assign o_valid    = r_vld;
    assign o_res      = r_res;

    always_comb begin
        n_vld = r_vld;
        n_res = r_res;
        if (i_load) begin
            n_vld = 1'b1;
            n_res = i_res;
        end else if (i_ready) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule

### hdl/bmp_pixel_stream_blitter.sv
// A result appears on o_valid once the byte completing the pixel has passed
// the input register and then the result register.
// Throughput: one byte per cycle unless a stalled result holds the input;
// 3 bytes per pixel in BGR mode, 4 in BGRA. Pad bytes and bytes that do not
// complete a pixel yield no result.
// Synchronous active-low reset clears stream state and loads register defaults.
module bmp_pixel_stream_blitter #(
    parameter int SCREEN_WIDTH  = bmpb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = bmpb_pkg::SCREEN_HEIGHT_DEF,
    parameter int MAX_IMAGE_DIM = bmpb_pkg::MAX_IMAGE_DIM_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bmpb_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [bmpb_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [bmpb_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [7:0]                         i_pixel_byte,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_on_screen,
    output logic [bmpb_pkg::FB_W-1:0]          o_fb_address,
    output logic [bmpb_pkg::COLOR_W-1:0]       o_pixel_color,
    output logic                               o_image_done
);

    bmpb_pkg::t_cfg    cfg;
    bmpb_pkg::t_result res, out_res;
    logic              res_vld, can_take;

    bmpb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bmpb_core #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MAX_IMAGE_DIM (MAX_IMAGE_DIM)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_pixel_byte (i_pixel_byte),
        .i_can_take   (can_take),
        .o_res_vld    (res_vld),
        .o_res        (res)
    );

    bmpb_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_vld),
        .i_res      (res),
        .o_can_take (can_take),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (out_res)
    );

    assign o_on_screen   = out_res.on_screen;
    assign o_fb_address  = out_res.fb_address;
    assign o_pixel_color = out_res.pixel_color;
    assign o_image_done  = out_res.image_done;

endmodule

### hdl/bmpb_check.sv
module bmpb_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic                          o_on_screen,
    input logic [bmpb_pkg::FB_W-1:0]     o_fb_address,
    input logic [bmpb_pkg::COLOR_W-1:0]  o_pixel_color,
    input logic                          o_image_done
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_off_screen_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_on_screen |-> o_fb_address == '0)
        else $error("off-screen pixel with non-zero address");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_image_done |=> !o_valid)
        else $error("transaction after final pixel");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_color)
                                && $stable(o_fb_address))
        else $error("stalled result changed");

endmodule

bind bmp_pixel_stream_blitter bmpb_check u_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_on_screen   (o_on_screen),
    .o_fb_address  (o_fb_address),
    .o_pixel_color (o_pixel_color),
    .o_image_done  (o_image_done)
);
